>>> rtl/core/scc_pkg.sv
// Shared types, sizes and codes for the photosensor cell counter.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  // Sizes
  localparam int unsigned BINS      = 64;
  localparam int unsigned CELLS     = 16384;
  localparam int unsigned BIN_W     = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned BIN_CNT_W = $clog2(BINS + 1);
  localparam int unsigned CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;

  // Fired map: rows of 64 bits, one valid flop per row
  localparam int unsigned MAP_COL_W    = 6;
  localparam int unsigned MAP_ROW_BITS = 1 << MAP_COL_W;
  localparam int unsigned MAP_ROWS     = (CELLS + MAP_ROW_BITS - 1) / MAP_ROW_BITS;
  localparam int unsigned MAP_ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Input opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_PHOTON = 2'd1;
  localparam logic [1:0] OP_EOE    = 2'd2;

  // Queued command kinds
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_PHOTON = 2'd1;
  localparam logic [1:0] CMD_EOE    = 2'd2;

  // Result kinds
  localparam logic RES_PHOTON  = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  // Configuration registers
  localparam int unsigned CFG_AW    = 4;
  localparam logic [1:0] REG_BIN_COUNT = 2'd0;
  localparam logic [1:0] REG_EFF_GAIN  = 2'd1;
  localparam logic [1:0] REG_PH_GAIN   = 2'd2;

  localparam logic [6:0]  BIN_COUNT_RST = 7'd2;
  localparam logic [15:0] EFF_GAIN_RST  = 16'd4096;
  localparam logic [15:0] PH_GAIN_RST   = 16'd256;

  typedef struct packed {
    logic [6:0]  bin_count;
    logic [15:0] eff_gain;
    logic [15:0] ph_gain;
  } cfg_t;

  // energy/aux carry bin energy/efficiency for loads and
  // photon energy/random value for photons
  typedef struct packed {
    logic [1:0]        kind;
    logic [BIN_W-1:0]  bin_idx;
    logic [15:0]       energy;
    logic [15:0]       aux;
    logic [CELL_W-1:0] cell_idx;
    logic [7:0]        chan;
    logic [31:0]       tstamp;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/scc_front.sv
// Front end: accepts input transactions, classifies and filters them, packs commands.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_front (
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    opcode,
  input  wire logic [5:0]    bin_index,
  input  wire logic [15:0]   bin_energy,
  input  wire logic [15:0]   bin_efficiency,
  input  wire logic [15:0]   photon_energy,
  input  wire logic          on_entry_face,
  input  wire logic [15:0]   random_value,
  input  wire logic [13:0]   cell_index,
  input  wire logic [7:0]    channel_id,
  input  wire logic [31:0]   arrival_time,
  input  wire logic          q_full,
  output logic               q_push,
  output scc_pkg::cmd_t      q_cmd
);

  logic accept;
  logic keep;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    q_cmd.kind     = scc_pkg::CMD_LOAD;
    q_cmd.bin_idx  = scc_pkg::BIN_W'(bin_index);
    q_cmd.energy   = bin_energy;
    q_cmd.aux      = bin_efficiency;
    q_cmd.cell_idx = scc_pkg::CELL_W'(cell_index);
    q_cmd.chan     = channel_id;
    q_cmd.tstamp   = arrival_time;
    keep           = 1'b0;
    case (opcode)
      scc_pkg::OP_LOAD: begin
        keep = (32'(bin_index) < scc_pkg::BINS);
      end
      scc_pkg::OP_PHOTON: begin
        // off-face photons and cells beyond the map never reach the back end
        q_cmd.kind   = scc_pkg::CMD_PHOTON;
        q_cmd.energy = photon_energy;
        q_cmd.aux    = random_value;
        keep         = on_entry_face && (32'(cell_index) < scc_pkg::CELLS);
      end
      scc_pkg::OP_EOE: begin
        q_cmd.kind = scc_pkg::CMD_EOE;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = accept && keep;

endmodule

`default_nettype wire

>>> rtl/core/scc_cmd_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire scc_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          rd,
  output logic               empty,
  output scc_pkg::cmd_t      head
);

  scc_pkg::cmd_t                  mem [scc_pkg::CMDQ_DEPTH];
  logic [scc_pkg::CMDQ_AW-1:0]    wptr;
  logic [scc_pkg::CMDQ_AW-1:0]    rptr;
  logic [scc_pkg::CMDQ_CW-1:0]    count;
  logic                           do_wr;
  logic                           do_rd;

  assign full  = (count == scc_pkg::CMDQ_CW'(scc_pkg::CMDQ_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == scc_pkg::CMDQ_AW'(scc_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == scc_pkg::CMDQ_AW'(scc_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/scc_back.sv
// Back end: efficiency table, nearest-bin walk, acceptance draw, fired map,
// event totals and the result register. Depends on scc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire scc_pkg::cfg_t cfg,
  input  wire logic          cmd_empty,
  input  wire scc_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_vld,
  input  wire logic          out_pop,
  output logic               res_kind,
  output logic [13:0]        res_cell,
  output logic [31:0]        res_time,
  output logic [14:0]        res_fired,
  output logic [31:0]        res_pe,
  output logic [7:0]         res_chan
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DRAW = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;

  logic [2:0] st;

  // efficiency table {energy, efficiency}
  logic [31:0] tbl [scc_pkg::BINS];
  logic [31:0] tbl_q;
  logic        tbl_we;

  // fired map
  logic [scc_pkg::MAP_ROW_BITS-1:0] fmap [scc_pkg::MAP_ROWS];
  logic [scc_pkg::MAP_ROW_BITS-1:0] map_q;
  logic [scc_pkg::MAP_ROWS-1:0]     row_vld;
  logic [scc_pkg::MAP_ROW_BITS-1:0] row_old;
  logic [scc_pkg::MAP_ROW_BITS-1:0] row_new;
  logic [scc_pkg::MAP_ROW_W-1:0]    cell_row;
  logic [scc_pkg::MAP_COL_W-1:0]    cell_col;
  logic                             map_we;
  logic                             bit_set;

  // photon being worked on
  logic [15:0]                 ph_energy;
  logic [15:0]                 ph_rnd;
  logic [scc_pkg::CELL_W-1:0]  ph_cell;
  logic [7:0]                  ph_chan;
  logic [31:0]                 ph_time;

  // walk
  logic [scc_pkg::BIN_CNT_W-1:0] nbins;
  logic [scc_pkg::BIN_CNT_W-1:0] rd_addr;
  logic [scc_pkg::BIN_CNT_W-1:0] q_idx;
  logic                          rd_vld;
  logic                          issue;
  logic [15:0]                   win_xa;
  logic [15:0]                   win_xb;
  logic [15:0]                   win_eff;
  logic signed [18:0]            sv, sxa, sxb, sxq;
  logic signed [18:0]            d_lo, d_hi, t_lo, t_hi, t_last;
  logic                          first_ok, mid_ok, last_ok;
  logic                          walk_done;
  logic [15:0]                   walk_eff;

  // draw
  logic [15:0] eff_sel;
  logic [31:0] prob;
  logic        draw_hit;

  // event totals
  logic [14:0] fired_count;
  logic [31:0] pe_sum;
  logic [7:0]  last_channel;
  logic [14:0] fired_new;
  logic [32:0] pe_wide;
  logic [31:0] pe_new;

  logic out_free;
  logic eoe_go;

  assign out_free = !out_vld || out_pop;

  // table size clipped to BINS
  assign nbins = (32'(cfg.bin_count) > scc_pkg::BINS) ?
                 scc_pkg::BIN_CNT_W'(scc_pkg::BINS) :
                 scc_pkg::BIN_CNT_W'(cfg.bin_count);

  assign tbl_we  = (st == ST_IDLE) && !cmd_empty && (cmd.kind == scc_pkg::CMD_LOAD);
  assign eoe_go  = (st == ST_IDLE) && !cmd_empty && (cmd.kind == scc_pkg::CMD_EOE) && out_free;
  assign cmd_pop = (st == ST_IDLE) && !cmd_empty &&
                   ((cmd.kind != scc_pkg::CMD_EOE) || out_free);

  assign issue = (st == ST_WALK) && (rd_addr < nbins);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[cmd.bin_idx] <= {cmd.energy, cmd.aux};
    end
    tbl_q <= tbl[rd_addr[scc_pkg::BIN_W-1:0]];
  end

  // Window: win_xa = x[j-2], win_xb = x[j-1], tbl_q = entry j.
  // Tests of bin j-1 complete when entry j arrives; the last bin is also
  // tested when entry n-1 arrives.
  always_comb begin
    sv       = signed'({3'b000, ph_energy});
    sxa      = signed'({3'b000, win_xa});
    sxb      = signed'({3'b000, win_xb});
    sxq      = signed'({3'b000, tbl_q[31:16]});
    d_lo     = sxb - sxa;
    t_lo     = (sxb - sv) <<< 1;
    d_hi     = sxq - sxb;
    t_hi     = (sv - sxb) <<< 1;
    t_last   = (sxq - sv) <<< 1;
    first_ok = (d_hi > t_hi);
    mid_ok   = (d_lo > t_lo) && first_ok;
    last_ok  = (d_hi > t_last);

    walk_done = 1'b0;
    walk_eff  = '0;
    if ((st == ST_WALK) && rd_vld && (q_idx != '0)) begin
      if ((q_idx == scc_pkg::BIN_CNT_W'(1)) ? first_ok : mid_ok) begin
        walk_done = 1'b1;
        if (q_idx == scc_pkg::BIN_CNT_W'(1)) begin
          walk_eff = (sv > sxb) ? win_eff : '0;
        end else begin
          walk_eff = win_eff;
        end
      end else if (q_idx == nbins - 1'b1) begin
        walk_done = 1'b1;
        walk_eff  = (last_ok && (sv < sxq)) ? tbl_q[15:0] : '0;
      end
    end
  end

  assign draw_hit = (32'({ph_rnd, 12'h000}) < prob);

  // fired map row update
  assign cell_row = scc_pkg::MAP_ROW_W'(ph_cell >> scc_pkg::MAP_COL_W);
  assign cell_col = scc_pkg::MAP_COL_W'(ph_cell);
  assign row_old  = row_vld[cell_row] ? map_q : '0;
  assign bit_set  = row_old[cell_col];
  assign row_new  = row_old | (scc_pkg::MAP_ROW_BITS'(1) << cell_col);
  assign map_we   = (st == ST_MARK) && out_free;

  assign fired_new = (!bit_set && (fired_count != '1)) ? fired_count + 1'b1 : fired_count;
  assign pe_wide   = {1'b0, pe_sum} + {17'd0, cfg.ph_gain};
  assign pe_new    = pe_wide[32] ? '1 : pe_wide[31:0];

  always_ff @(posedge clk) begin
    if (map_we) begin
      fmap[cell_row] <= row_new;
    end
    map_q <= fmap[cell_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      out_vld      <= 1'b0;
      rd_vld       <= 1'b0;
      rd_addr      <= '0;
      row_vld      <= '0;
      fired_count  <= '0;
      pe_sum       <= '0;
      last_channel <= '0;
    end else begin
      if (out_pop) begin
        out_vld <= 1'b0;
      end
      rd_vld <= issue;
      case (st)
        ST_IDLE: begin
          if (!cmd_empty && (cmd.kind == scc_pkg::CMD_PHOTON)) begin
            rd_addr <= '0;
            if (nbins >= scc_pkg::BIN_CNT_W'(2)) begin
              st <= ST_WALK;
            end
          end
          if (eoe_go) begin
            out_vld     <= 1'b1;
            row_vld     <= '0;
            fired_count <= '0;
            pe_sum      <= '0;
          end
        end
        ST_WALK: begin
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (walk_done) begin
            st <= ST_MUL;
          end
        end
        ST_MUL: begin
          st <= ST_DRAW;
        end
        ST_DRAW: begin
          st <= draw_hit ? ST_MARK : ST_IDLE;
        end
        ST_MARK: begin
          if (out_free) begin
            out_vld           <= 1'b1;
            row_vld[cell_row] <= 1'b1;
            fired_count       <= fired_new;
            pe_sum            <= pe_new;
            last_channel      <= ph_chan;
            st                <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_pop && (cmd.kind == scc_pkg::CMD_PHOTON)) begin
      ph_energy <= cmd.energy;
      ph_rnd    <= cmd.aux;
      ph_cell   <= cmd.cell_idx;
      ph_chan   <= cmd.chan;
      ph_time   <= cmd.tstamp;
    end
    q_idx <= rd_addr;
    if (rd_vld) begin
      win_xa  <= win_xb;
      win_xb  <= tbl_q[31:16];
      win_eff <= tbl_q[15:0];
    end
    if (walk_done) begin
      eff_sel <= walk_eff;
    end
    if (st == ST_MUL) begin
      prob <= eff_sel * cfg.eff_gain;
    end
    if (eoe_go) begin
      res_kind  <= scc_pkg::RES_SUMMARY;
      res_cell  <= '0;
      res_time  <= '0;
      res_fired <= fired_count;
      res_pe    <= pe_sum;
      res_chan  <= last_channel;
    end else if (map_we) begin
      res_kind  <= scc_pkg::RES_PHOTON;
      res_cell  <= 14'(ph_cell);
      res_time  <= ph_time;
      res_fired <= fired_new;
      res_pe    <= pe_new;
      res_chan  <= ph_chan;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sipm_photon_cell_counter.sv
// Photosensor cell counter top level: configuration registers and the
// front end / command queue / back end. Depends on scc_pkg and the scc_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Counts the microcells fired during one event. Items enter through a queue
// style port (push/full) and results leave through one (empty/pop); one result
// register sits at the output, and a four-entry command queue lets new
// transactions be taken while the back end works or a result waits.
// Opcode 0 writes one efficiency table bin (energy, Q0.16 efficiency); the
// table is undefined until written, so load every bin below bin_count before
// sending photons. Opcode 1 is a photon: off-face photons and out-of-range
// cells are dropped in the front end. The back end finds the nearest bin by
// walking the table one entry per cycle through its single read port, scales
// the efficiency by efficiency_gain and compares it with random_value; an
// accepted photon sets its cell in the fired map, adds photon_gain to the
// saturating sum and returns a record with cell, time and running totals.
// Opcode 2 returns the event summary and clears the totals and the fired map;
// the map is cleared at once through one valid flop per 64-cell row, so there
// is no clearing pass after reset or between events. Opcode 3 is dropped.
// In the back end a load and an end of event are handled in the idle state;
// a photon is dropped there when bin_count is below 2, else it walks the
// table until the nearest-bin search settles, then passes the multiply and
// draw states; an accepted photon then waits in the mark state until the
// result register is free. The table walk sets the photon rate, and the
// back end takes the next command only when it is back in idle.
// Registers (APB, 32-bit): 0x0 bin_count, 0x4 efficiency_gain (Q4.12),
// 0x8 photon_gain (Q8.8); write them only while the block is idle.
module sipm_photon_cell_counter (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [scc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input items
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  opcode,
  input  wire logic [5:0]  bin_index,
  input  wire logic [15:0] bin_energy,
  input  wire logic [15:0] bin_efficiency,
  input  wire logic [15:0] photon_energy,
  input  wire logic        on_entry_face,
  input  wire logic [15:0] random_value,
  input  wire logic [13:0] cell_index,
  input  wire logic [7:0]  channel_id,
  input  wire logic [31:0] arrival_time,
  // results
  output logic             empty,
  input  wire logic        pop,
  output logic             result_kind,
  output logic [13:0]      cell_out,
  output logic [31:0]      time_out,
  output logic [14:0]      fired_cells,
  output logic [31:0]      photoelectrons,
  output logic [7:0]       channel_out
);

  scc_pkg::cfg_t cfg;
  logic [1:0]    reg_idx;
  logic          cfg_wr;

  scc_pkg::cmd_t f_cmd;
  scc_pkg::cmd_t q_head;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  logic          out_vld;

  // APB: zero wait states, registers at 4-byte strides
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bin_count <= scc_pkg::BIN_COUNT_RST;
      cfg.eff_gain  <= scc_pkg::EFF_GAIN_RST;
      cfg.ph_gain   <= scc_pkg::PH_GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        scc_pkg::REG_BIN_COUNT: cfg.bin_count <= pwdata[6:0];
        scc_pkg::REG_EFF_GAIN:  cfg.eff_gain  <= pwdata[15:0];
        scc_pkg::REG_PH_GAIN:   cfg.ph_gain   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      scc_pkg::REG_BIN_COUNT: prdata = {25'd0, cfg.bin_count};
      scc_pkg::REG_EFF_GAIN:  prdata = {16'd0, cfg.eff_gain};
      scc_pkg::REG_PH_GAIN:   prdata = {16'd0, cfg.ph_gain};
      default:                prdata = '0;
    endcase
  end

  scc_front u_front (
    .push           (push),
    .full           (full),
    .opcode         (opcode),
    .bin_index      (bin_index),
    .bin_energy     (bin_energy),
    .bin_efficiency (bin_efficiency),
    .photon_energy  (photon_energy),
    .on_entry_face  (on_entry_face),
    .random_value   (random_value),
    .cell_index     (cell_index),
    .channel_id     (channel_id),
    .arrival_time   (arrival_time),
    .q_full         (q_full),
    .q_push         (f_push),
    .q_cmd          (f_cmd)
  );

  scc_cmd_fifo u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_push),
    .wr_cmd (f_cmd),
    .full   (q_full),
    .rd     (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  scc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (q_empty),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_vld   (out_vld),
    .out_pop   (pop),
    .res_kind  (result_kind),
    .res_cell  (cell_out),
    .res_time  (time_out),
    .res_fired (fired_cells),
    .res_pe    (photoelectrons),
    .res_chan  (channel_out)
  );

  assign empty = !out_vld;

endmodule

`default_nettype wire
